@@ hdl/hrcm_pkg.sv @@
// ----------------------------------------------------------------------------
// hrcm_pkg
// Shared constants, tables and helpers for the hue rotation color matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package hrcm_pkg;

   localparam int CHANNEL_BITS_DEF   = 8;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int COEF_INT_BITS      = 4;
   localparam int ANGLE_BITS         = 9;
   localparam int TRIG_FRAC_BITS     = 14;
   localparam int TRIG_BITS          = TRIG_FRAC_BITS + 2;
   localparam int TERM_BITS          = 12;
   localparam int MAG_BITS           = 26;
   localparam int NUM_BITS           = MAG_BITS + 2;
   localparam int NUM_COEF           = 9;
   localparam int NUM_CHAN           = 3;
   localparam int DIVISOR            = 1000;
   localparam int DIVISOR_HALF       = DIVISOR / 2;
   localparam int DIVISOR_SHIFT      = 3;
   localparam int DIVISOR_ODD        = DIVISOR >> DIVISOR_SHIFT;

   localparam logic [ANGLE_BITS-1:0] FULL_TURN    = ANGLE_BITS'(360);
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(90);
   localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(180);
   localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_TURN = ANGLE_BITS'(270);

   localparam logic [TRIG_FRAC_BITS:0] SINE_QUARTER [91] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // matrix terms in thousandths, row-major
   localparam logic signed [TERM_BITS-1:0] MAT_BASE [NUM_COEF] = '{
      12'sd299, 12'sd587, 12'sd114, 12'sd299, 12'sd587, 12'sd114,
      12'sd299, 12'sd587, 12'sd114
   };
   localparam logic signed [TERM_BITS-1:0] MAT_COS [NUM_COEF] = '{
      12'sd701, -12'sd587, -12'sd114, -12'sd299, 12'sd413, -12'sd114,
      -12'sd300, -12'sd588, 12'sd886
   };
   localparam logic signed [TERM_BITS-1:0] MAT_SIN [NUM_COEF] = '{
      12'sd168, 12'sd330, -12'sd497, -12'sd328, 12'sd35, 12'sd292,
      12'sd1250, -12'sd1050, -12'sd203
   };

   // sine of an angle in 0..359 degrees, Q1.14
   function automatic logic signed [TRIG_BITS-1:0] sin_deg(input logic [ANGLE_BITS-1:0] d);
      logic [ANGLE_BITS-1:0] idx;
      logic                  neg;
      logic signed [TRIG_BITS-1:0] mag;
      neg = 1'b0;
      if (d <= QUARTER_TURN) begin
         idx = d;
      end else if (d <= HALF_TURN) begin
         idx = HALF_TURN - d;
      end else if (d <= THREE_QUARTER_TURN) begin
         idx = d - HALF_TURN;
         neg = 1'b1;
      end else begin
         idx = FULL_TURN - d;
         neg = 1'b1;
      end
      mag = $signed({1'b0, SINE_QUARTER[idx[6:0]]});
      sin_deg = neg ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

@@ hdl/hrcm_if.sv @@
// ----------------------------------------------------------------------------
// hrcm_if
// Valid/ready channels of the hue rotation color matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrcm_req_if #(
   parameter int CHANNEL_BITS = hrcm_pkg::CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in,
                 output ready);
   modport monitor (input valid, input ready, input red_in, input green_in,
                    input blue_in);
endinterface

interface hrcm_rsp_if #(
   parameter int CHANNEL_BITS = hrcm_pkg::CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_out;
   logic [CHANNEL_BITS-1:0] green_out;
   logic [CHANNEL_BITS-1:0] blue_out;
   logic                    clipped;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output clipped, input ready);
   modport sink (input valid, input red_out, input green_out, input blue_out,
                 input clipped, output ready);
   modport monitor (input valid, input ready, input red_out, input green_out,
                    input blue_out, input clipped);
endinterface

interface hrcm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [hrcm_pkg::ANGLE_BITS-1:0] hue_angle;

   modport source (output valid, output hue_angle, input ready);
   modport sink (input valid, input hue_angle, output ready);
   modport monitor (input valid, input ready, input hue_angle);
endinterface

`default_nettype wire

@@ hdl/hrcm_coef_builder.sv @@
// ----------------------------------------------------------------------------
// hrcm_coef_builder
// Rebuilds the nine matrix coefficients from the hue angle, one at a time in a load
// and a store state, with a reciprocal multiply for the divide by one thousand.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcm_coef_builder #(
   parameter int COEF_FRAC_BITS = hrcm_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_valid,
   input  logic [hrcm_pkg::ANGLE_BITS-1:0]        wr_angle,
   output logic                                   busy,
   output logic signed [COEF_FRAC_BITS+hrcm_pkg::COEF_INT_BITS-1:0]
                                                  coef [hrcm_pkg::NUM_COEF]
);

   localparam int COEF_BITS   = COEF_FRAC_BITS + hrcm_pkg::COEF_INT_BITS;
   localparam int SHL         = (COEF_FRAC_BITS > hrcm_pkg::TRIG_FRAC_BITS) ?
                                COEF_FRAC_BITS - hrcm_pkg::TRIG_FRAC_BITS : 0;
   localparam int SHR         = (COEF_FRAC_BITS < hrcm_pkg::TRIG_FRAC_BITS) ?
                                hrcm_pkg::TRIG_FRAC_BITS - COEF_FRAC_BITS : 0;
   localparam int DIVD_BITS   = hrcm_pkg::MAG_BITS + SHL + 1;
   localparam int ODD_BITS    = DIVD_BITS - hrcm_pkg::DIVISOR_SHIFT;
   localparam int RECIP_SHIFT = ODD_BITS + $clog2(hrcm_pkg::DIVISOR_ODD);
   localparam int RECIP_BITS  = ODD_BITS + 1;
   localparam int PROD_BITS   = ODD_BITS + RECIP_BITS;
   localparam int IDX_BITS    = $clog2(hrcm_pkg::NUM_COEF);
   localparam int NB          = hrcm_pkg::NUM_BITS;
   localparam logic [IDX_BITS-1:0]   IDX_LAST = IDX_BITS'(hrcm_pkg::NUM_COEF - 1);
   // ceil(2^RECIP_SHIFT / 125), exact floor division over the whole dividend range
   localparam logic [RECIP_BITS-1:0] RECIP    = RECIP_BITS'(
      ((longint'(1) << RECIP_SHIFT) + longint'(hrcm_pkg::DIVISOR_ODD - 1))
      / longint'(hrcm_pkg::DIVISOR_ODD));

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TRIG,
      ST_LOAD,
      ST_STORE
   } state_type;

   state_type                               state_ff, state_in;
   logic [hrcm_pkg::ANGLE_BITS-1:0]         angle_ff, angle_in;
   logic signed [hrcm_pkg::TRIG_BITS-1:0]   sin_ff, sin_in;
   logic signed [hrcm_pkg::TRIG_BITS-1:0]   cos_ff, cos_in;
   logic [IDX_BITS-1:0]                     idx_ff, idx_in;
   logic                                    neg_ff, neg_in;
   logic [DIVD_BITS-1:0]                    divd_ff, divd_in;
   logic signed [COEF_BITS-1:0]             coef_ff [hrcm_pkg::NUM_COEF];
   logic signed [COEF_BITS-1:0]             coef_in [hrcm_pkg::NUM_COEF];

   logic [hrcm_pkg::ANGLE_BITS-1:0]         wrap_ang;
   logic [hrcm_pkg::ANGLE_BITS-1:0]         cos_ang;
   logic signed [NB-1:0]                    base_term;
   logic signed [NB-1:0]                    cos_term;
   logic signed [NB-1:0]                    sin_term;
   logic signed [NB-1:0]                    numer;
   logic [NB-1:0]                           numer_abs;
   logic [DIVD_BITS-1:0]                    dividend;
   logic [ODD_BITS-1:0]                     divd_odd;
   logic [PROD_BITS-1:0]                    recip_prod;
   logic [COEF_BITS-1:0]                    coef_mag;

   always_comb begin
      wrap_ang = (angle_ff >= hrcm_pkg::FULL_TURN) ? angle_ff - hrcm_pkg::FULL_TURN
                                                    : angle_ff;
      cos_ang  = wrap_ang + hrcm_pkg::QUARTER_TURN;
      if (cos_ang >= hrcm_pkg::FULL_TURN) begin
         cos_ang = cos_ang - hrcm_pkg::FULL_TURN;
      end

      base_term = NB'(hrcm_pkg::MAT_BASE[idx_ff]) <<< hrcm_pkg::TRIG_FRAC_BITS;
      cos_term  = hrcm_pkg::MAT_COS[idx_ff] * cos_ff;
      sin_term  = hrcm_pkg::MAT_SIN[idx_ff] * sin_ff;
      numer     = base_term + cos_term + sin_term;
      numer_abs = numer[NB-1] ? NB'(-numer) : NB'(numer);
      dividend  = ((DIVD_BITS'(numer_abs[hrcm_pkg::MAG_BITS-1:0]) << SHL) >> SHR)
                  + DIVD_BITS'(hrcm_pkg::DIVISOR_HALF);

      // divide by 8 with a shift, then by 125 with a reciprocal multiply
      divd_odd   = divd_ff[DIVD_BITS-1:hrcm_pkg::DIVISOR_SHIFT];
      recip_prod = PROD_BITS'(divd_odd) * PROD_BITS'(RECIP);
      coef_mag   = COEF_BITS'(recip_prod >> RECIP_SHIFT);
   end

   always_comb begin
      state_in = state_ff;
      angle_in = angle_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      idx_in   = idx_ff;
      neg_in   = neg_ff;
      divd_in  = divd_ff;
      coef_in  = coef_ff;
      case (state_ff)
         ST_IDLE: begin
            if (wr_valid) begin
               angle_in = wr_angle;
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            sin_in   = hrcm_pkg::sin_deg(wrap_ang);
            cos_in   = hrcm_pkg::sin_deg(cos_ang);
            idx_in   = '0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            neg_in   = numer[NB-1];
            divd_in  = dividend;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            coef_in[idx_ff] = neg_ff ? $signed(COEF_BITS'(-coef_mag)) : $signed(coef_mag);
            if (idx_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TRIG;
         angle_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         angle_ff <= angle_in;
         idx_ff   <= idx_in;
      end
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
      neg_ff  <= neg_in;
      divd_ff <= divd_in;
      coef_ff <= coef_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign coef = coef_ff;

endmodule

`default_nettype wire

@@ hdl/hrcm_pixel_pipe.sv @@
// ----------------------------------------------------------------------------
// hrcm_pixel_pipe
// Three-stage pixel datapath: input register, coefficient products,
// row sums with rounding and saturation into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcm_pixel_pipe #(
   parameter int CHANNEL_BITS   = hrcm_pkg::CHANNEL_BITS_DEF,
   parameter int COEF_FRAC_BITS = hrcm_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    busy,
   input  logic signed [COEF_FRAC_BITS+hrcm_pkg::COEF_INT_BITS-1:0]
                                   coef [hrcm_pkg::NUM_COEF],
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [CHANNEL_BITS-1:0] in_chan [hrcm_pkg::NUM_CHAN],
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [CHANNEL_BITS-1:0] out_chan [hrcm_pkg::NUM_CHAN],
   output logic                    out_clipped
);

   localparam int COEF_BITS = COEF_FRAC_BITS + hrcm_pkg::COEF_INT_BITS;
   localparam int PROD_BITS = COEF_BITS + CHANNEL_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int VAL_BITS  = SUM_BITS - COEF_FRAC_BITS;
   localparam int NC        = hrcm_pkg::NUM_CHAN;
   localparam logic signed [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(2 ** (COEF_FRAC_BITS - 1));
   localparam logic signed [VAL_BITS-1:0] TOP_VAL    = VAL_BITS'((2 ** CHANNEL_BITS) - 1);

   logic                        v1_ff, v1_in;
   logic                        v2_ff, v2_in;
   logic                        v3_ff, v3_in;
   logic [CHANNEL_BITS-1:0]     ch_ff [NC];
   logic [CHANNEL_BITS-1:0]     ch_in [NC];
   logic signed [PROD_BITS-1:0] prod_ff [hrcm_pkg::NUM_COEF];
   logic signed [PROD_BITS-1:0] prod_in [hrcm_pkg::NUM_COEF];
   logic [CHANNEL_BITS-1:0]     res_ff [NC];
   logic [CHANNEL_BITS-1:0]     res_in [NC];
   logic                        clip_ff, clip_in;

   logic en1, en2, en3;
   logic signed [SUM_BITS-1:0]  row_sum [NC];
   logic signed [VAL_BITS-1:0]  row_val [NC];

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1 && !busy;

   always_comb begin
      v1_in   = v1_ff;
      v2_in   = v2_ff;
      v3_in   = v3_ff;
      ch_in   = ch_ff;
      prod_in = prod_ff;
      res_in  = res_ff;
      clip_in = clip_ff;

      if (en1) begin
         v1_in = in_valid && in_ready;
         ch_in = in_chan;
      end

      if (en2) begin
         v2_in = v1_ff;
         for (int r = 0; r < NC; r++) begin
            for (int k = 0; k < NC; k++) begin
               prod_in[r*NC+k] = coef[r*NC+k] * $signed({1'b0, ch_ff[k]});
            end
         end
      end

      for (int r = 0; r < NC; r++) begin
         row_sum[r] = SUM_BITS'(prod_ff[r*NC]) + SUM_BITS'(prod_ff[r*NC+1])
                      + SUM_BITS'(prod_ff[r*NC+2]) + ROUND_BIAS;
         row_val[r] = VAL_BITS'(row_sum[r] >>> COEF_FRAC_BITS);
      end

      if (en3) begin
         v3_in   = v2_ff;
         clip_in = 1'b0;
         for (int r = 0; r < NC; r++) begin
            if (row_val[r] < 0) begin
               res_in[r] = '0;
               clip_in   = 1'b1;
            end else if (row_val[r] > TOP_VAL) begin
               res_in[r] = '1;
               clip_in   = 1'b1;
            end else begin
               res_in[r] = row_val[r][CHANNEL_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      ch_ff   <= ch_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      clip_ff <= clip_in;
   end

   assign out_valid   = v3_ff;
   assign out_chan    = res_ff;
   assign out_clipped = clip_ff;

endmodule

`default_nettype wire

@@ hdl/hue_rotation_color_matrix_core.sv @@
// ----------------------------------------------------------------------------
// hue_rotation_color_matrix_core
// Rotates the hue of an RGB pixel stream by a programmed angle in degrees.
// ----------------------------------------------------------------------------
// The core takes one pixel request per clock while req_bus.ready is high. A
// request passes an input register, a register of the nine coefficient
// products and a result register with rounding and saturation, which offers
// its result on rsp_bus; when the result side holds off the three stages fill
// up and req_bus.ready drops. After reset and after every angle write a trig
// state looks up sine and cosine, then the nine coefficients are rebuilt one
// at a time, each in a load and a store state (divide by one thousand by
// reciprocal multiply); during the rebuild req_bus.ready and csr_bus.ready stay
// low. Angles of 360 and above wrap. Interfaces are instantiated with the same
// CHANNEL_BITS as the core.
`default_nettype none

module hue_rotation_color_matrix_core #(
   parameter int CHANNEL_BITS   = hrcm_pkg::CHANNEL_BITS_DEF,
   parameter int COEF_FRAC_BITS = hrcm_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hrcm_csr_if.sink    csr_bus,
   hrcm_req_if.sink    req_bus,
   hrcm_rsp_if.source  rsp_bus
);

   localparam int COEF_BITS = COEF_FRAC_BITS + hrcm_pkg::COEF_INT_BITS;

   logic                        busy;
   logic                        csr_write;
   logic signed [COEF_BITS-1:0] coef [hrcm_pkg::NUM_COEF];
   logic [CHANNEL_BITS-1:0]     req_chan [hrcm_pkg::NUM_CHAN];
   logic [CHANNEL_BITS-1:0]     rsp_chan [hrcm_pkg::NUM_CHAN];

   assign csr_bus.ready = !busy;
   assign csr_write     = csr_bus.valid && !busy;

   assign req_chan[0] = req_bus.red_in;
   assign req_chan[1] = req_bus.green_in;
   assign req_chan[2] = req_bus.blue_in;

   hrcm_coef_builder #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_coef_builder (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_write),
      .wr_angle (csr_bus.hue_angle),
      .busy     (busy),
      .coef     (coef)
   );

   hrcm_pixel_pipe #(
      .CHANNEL_BITS   (CHANNEL_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_pixel_pipe (
      .clock       (clock),
      .reset       (reset),
      .busy        (busy),
      .coef        (coef),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .in_chan     (req_chan),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_chan    (rsp_chan),
      .out_clipped (rsp_bus.clipped)
   );

   assign rsp_bus.red_out   = rsp_chan[0];
   assign rsp_bus.green_out = rsp_chan[1];
   assign rsp_bus.blue_out  = rsp_chan[2];

endmodule

`default_nettype wire

@@ hdl/hrcm_checker.sv @@
// ----------------------------------------------------------------------------
// hrcm_checker
// Port-level checks of the hue rotation color matrix core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcm_checker #(
   parameter int CHANNEL_BITS = hrcm_pkg::CHANNEL_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    csr_valid,
   input logic                    csr_ready,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [CHANNEL_BITS-1:0] rsp_red_out,
   input logic [CHANNEL_BITS-1:0] rsp_green_out,
   input logic [CHANNEL_BITS-1:0] rsp_blue_out,
   input logic                    rsp_clipped
);

   // coefficient rebuild after reset blocks both channels
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !csr_ready)
      else $error("ready high right after reset");

   // an angle write starts a rebuild
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready && !csr_ready)
      else $error("request taken during coefficient rebuild");

   // no request accepted while the csr side is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> csr_ready)
      else $error("request ready while rebuilding");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out)
         && $stable(rsp_clipped))
      else $error("stalled result changed");

endmodule

bind hue_rotation_color_matrix_core hrcm_checker #(
   .CHANNEL_BITS (CHANNEL_BITS)
) u_hrcm_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_valid     (csr_bus.valid),
   .csr_ready     (csr_bus.ready),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_red_out   (rsp_bus.red_out),
   .rsp_green_out (rsp_bus.green_out),
   .rsp_blue_out  (rsp_bus.blue_out),
   .rsp_clipped   (rsp_bus.clipped)
);

`default_nettype wire
